### rtl/core/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg
// Shared types, constants and rounding/saturation helpers for the PID step
// with integral separation.
// ----------------------------------------------------------------------------
package pse_pkg;

   localparam int DATA_W  = 32;
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 32;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int RND_W   = ACC_W - 16;
   localparam int SUM_W   = RND_W + 2;
   localparam int CSR_IDX_W = 3;

   localparam logic signed [DATA_W-1:0] FX_PI     = 32'sd205887;
   localparam logic signed [DATA_W-1:0] FX_TWO_PI = 32'sd411775;
   localparam logic [DATA_W:0]          FX_HALF   = 33'd32768;
   localparam logic [DATA_W:0]          FX_THIRTY = 33'd1966080;
   localparam logic signed [MUL_A_W-1:0] W_OLD    = 33'sd45875;
   localparam logic signed [MUL_B_W-1:0] W_NEW    = 32'sd19661;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P         = 3'd0,
      CSR_GAIN_I         = 3'd1,
      CSR_GAIN_D         = 3'd2,
      CSR_INTEGRAL_LIMIT = 3'd3,
      CSR_ANGLE_MODE     = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR,
      ST_WRAP,
      ST_MUL_I,
      ST_MUL_OLD,
      ST_MUL_NEW,
      ST_MUL_P,
      ST_FILT,
      ST_MUL_D,
      ST_DSUM,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MSEL_I,
      MSEL_OLD,
      MSEL_NEW,
      MSEL_P,
      MSEL_D
   } mul_sel_type;

   typedef struct packed {
      logic        ld_in;
      logic        ld_err;
      logic        ld_wrap;
      logic        ld_integ;
      logic        ld_acc;
      logic        add_acc;
      logic        ld_filt;
      logic        add_dterm;
      logic        ld_out;
      mul_sel_type mul_sel;
   } ctrl_type;

   // add one half lsb, then floor of the shift by 16
   function automatic logic signed [RND_W-1:0] round16(input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] t;
      t = x + $signed({{(ACC_W-16){1'b0}}, 16'h8000});
      return t[ACC_W-1:16];
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [SUM_W-1:0] x);
      logic all_one;
      logic all_zero;
      all_one  = &x[SUM_W-1:DATA_W-1];
      all_zero = ~|x[SUM_W-1:DATA_W-1];
      if (all_one || all_zero) begin
         return x[DATA_W-1:0];
      end else if (x[SUM_W-1]) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end
   endfunction

endpackage

### rtl/core/pse_mul.sv
// ----------------------------------------------------------------------------
// pse_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pse_mul (
   input  logic                                  clock,
   input  logic signed [pse_pkg::MUL_A_W-1:0]    op_a,
   input  logic signed [pse_pkg::MUL_B_W-1:0]    op_b,
   output logic signed [pse_pkg::PROD_W-1:0]     prod
);

   logic signed [pse_pkg::PROD_W-1:0] prod_ff;
   logic signed [pse_pkg::PROD_W-1:0] prod_in;

   assign prod_in = pse_pkg::PROD_W'(op_a) * pse_pkg::PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

### rtl/core/pse_ctrl.sv
// ----------------------------------------------------------------------------
// pse_ctrl
// Step sequencer: walks one item through the shared multiplier schedule.
// ----------------------------------------------------------------------------
module pse_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               out_busy,
   output pse_pkg::ctrl_type  ctrl
);

   pse_pkg::state_type state_ff;
   pse_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      ctrl      = '0;
      ctrl.mul_sel = pse_pkg::MSEL_I;
      req_stall = (state_ff != pse_pkg::ST_IDLE);
      case (state_ff)
         pse_pkg::ST_IDLE: begin
            if (req_valid) begin
               ctrl.ld_in = 1'b1;
               state_in   = pse_pkg::ST_ERR;
            end
         end
         pse_pkg::ST_ERR: begin
            ctrl.ld_err = 1'b1;
            state_in    = pse_pkg::ST_WRAP;
         end
         pse_pkg::ST_WRAP: begin
            ctrl.ld_wrap = 1'b1;
            state_in     = pse_pkg::ST_MUL_I;
         end
         pse_pkg::ST_MUL_I: begin
            ctrl.mul_sel = pse_pkg::MSEL_I;
            state_in     = pse_pkg::ST_MUL_OLD;
         end
         pse_pkg::ST_MUL_OLD: begin
            ctrl.mul_sel  = pse_pkg::MSEL_OLD;
            ctrl.ld_integ = 1'b1;
            state_in      = pse_pkg::ST_MUL_NEW;
         end
         pse_pkg::ST_MUL_NEW: begin
            ctrl.mul_sel = pse_pkg::MSEL_NEW;
            ctrl.ld_acc  = 1'b1;
            state_in     = pse_pkg::ST_MUL_P;
         end
         pse_pkg::ST_MUL_P: begin
            ctrl.mul_sel = pse_pkg::MSEL_P;
            ctrl.add_acc = 1'b1;
            state_in     = pse_pkg::ST_FILT;
         end
         pse_pkg::ST_FILT: begin
            ctrl.ld_filt = 1'b1;
            state_in     = pse_pkg::ST_MUL_D;
         end
         pse_pkg::ST_MUL_D: begin
            ctrl.mul_sel = pse_pkg::MSEL_D;
            state_in     = pse_pkg::ST_DSUM;
         end
         pse_pkg::ST_DSUM: begin
            ctrl.add_dterm = 1'b1;
            state_in       = pse_pkg::ST_OUT;
         end
         pse_pkg::ST_OUT: begin
            // wait for the output register to free up
            if (!out_busy) begin
               ctrl.ld_out = 1'b1;
               state_in    = pse_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pse_pkg::ST_IDLE;
         end
      endcase
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == pse_pkg::ST_ERR))
      else $error("accepted beat did not start the sequence");

   a_out_returns_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.ld_out |=> (state_ff == pse_pkg::ST_IDLE))
      else $error("sequencer did not return to idle after the result");

   a_out_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pse_pkg::ST_OUT && out_busy) |=> (state_ff == pse_pkg::ST_OUT))
      else $error("result step left while the output register was full");

endmodule

### rtl/core/pid_step_integral_separation_top.sv
// ----------------------------------------------------------------------------
// pid_step_integral_separation_top
// PID step with integral separation in Q16.16 on one shared multiplier.
// ----------------------------------------------------------------------------
// The req channel takes a target and a measured value per beat; the rsp
// channel returns one drive value per beat. Both use valid/stall: a beat moves
// at a rising edge with valid high and stall low.
// Gains, the integral limit and angle mode are written through the csr port
// (write enable, index, data); the user must write them only while no item is
// in flight, as the block does not enforce it. An item passes the accept, ten
// sequencer steps that feed the five products (error*Ki, the two filter taps,
// error*Kp, filtered*Kd) through the single registered multiplier; the last
// loads the drive value into the output register. One item is worked on at a
// time; req_stall is high from accept until the sequencer is back in idle.
// The output register lets the next item be accepted while a result still
// waits; if rsp_stall holds the previous result, the final step waits for it.
// Synchronous reset clears the csr registers, the previous error, the integral
// and the filtered derivative, and empties the output register.
// ----------------------------------------------------------------------------
module pid_step_integral_separation_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   csr_write_enable,
   input  logic [pse_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [pse_pkg::DATA_W-1:0]             csr_write_data,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [pse_pkg::DATA_W-1:0]      req_target_value,
   input  logic signed [pse_pkg::DATA_W-1:0]      req_measured_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [pse_pkg::DATA_W-1:0]      rsp_drive_value
);

   localparam int DW = pse_pkg::DATA_W;

   logic signed [DW-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [DW-2:0]        integral_limit_ff;
   logic                 angle_mode_ff;

   logic signed [DW-1:0] tgt_ff, meas_ff, err_ff;
   logic signed [DW-1:0] prev_err_ff, integ_ff, filt_ff;
   logic signed [pse_pkg::ACC_W-1:0] acc_ff;
   logic signed [pse_pkg::SUM_W-1:0] pd_ff;
   logic                 rsp_valid_ff;
   logic signed [DW-1:0] rsp_drive_ff;

   pse_pkg::ctrl_type ctrl;

   logic signed [pse_pkg::MUL_A_W-1:0] op_a;
   logic signed [pse_pkg::MUL_B_W-1:0] op_b;
   logic signed [pse_pkg::PROD_W-1:0]  prod;
   logic signed [pse_pkg::ACC_W-1:0]   prod_x;
   logic signed [pse_pkg::SUM_W-1:0]   prod_rnd;

   logic signed [DW:0]   diff;
   logic signed [DW:0]   err_x;
   logic [DW:0]          mag;
   logic signed [DW:0]   deriv;
   logic [DW:0]          thresh;
   logic signed [DW-1:0] integ_sat;
   logic signed [DW-1:0] integ_in;
   logic signed [DW-1:0] limit_pos;

   // ------------------------------------------------------------------ csr
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff         <= '0;
         gain_i_ff         <= '0;
         gain_d_ff         <= '0;
         integral_limit_ff <= '0;
         angle_mode_ff     <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            pse_pkg::CSR_GAIN_P:         gain_p_ff         <= csr_write_data;
            pse_pkg::CSR_GAIN_I:         gain_i_ff         <= csr_write_data;
            pse_pkg::CSR_GAIN_D:         gain_d_ff         <= csr_write_data;
            pse_pkg::CSR_INTEGRAL_LIMIT: integral_limit_ff <= csr_write_data[DW-2:0];
            pse_pkg::CSR_ANGLE_MODE:     angle_mode_ff     <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------ sequencer
   pse_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .out_busy  (rsp_valid_ff && rsp_stall),
      .ctrl      (ctrl)
   );

   // ----------------------------------------------------------- multiplier
   assign err_x = {err_ff[DW-1], err_ff};
   assign deriv = err_x - {prev_err_ff[DW-1], prev_err_ff};

   always_comb begin
      case (ctrl.mul_sel)
         pse_pkg::MSEL_I: begin
            op_a = err_x;
            op_b = gain_i_ff;
         end
         pse_pkg::MSEL_OLD: begin
            op_a = {filt_ff[DW-1], filt_ff};
            op_b = pse_pkg::MUL_B_W'(pse_pkg::W_OLD);
         end
         pse_pkg::MSEL_NEW: begin
            op_a = deriv;
            op_b = pse_pkg::W_NEW;
         end
         pse_pkg::MSEL_P: begin
            op_a = err_x;
            op_b = gain_p_ff;
         end
         pse_pkg::MSEL_D: begin
            op_a = {filt_ff[DW-1], filt_ff};
            op_b = gain_d_ff;
         end
         default: begin
            op_a = err_x;
            op_b = gain_i_ff;
         end
      endcase
   end

   pse_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign prod_x   = {prod[pse_pkg::PROD_W-1], prod};
   assign prod_rnd = pse_pkg::SUM_W'(pse_pkg::round16(prod_x));

   // ------------------------------------------------------------- datapath
   assign diff   = {tgt_ff[DW-1], tgt_ff} - {meas_ff[DW-1], meas_ff};
   assign mag    = err_ff[DW-1] ? -err_x : err_x;
   assign thresh = angle_mode_ff ? pse_pkg::FX_HALF : pse_pkg::FX_THIRTY;
   assign limit_pos = {1'b0, integral_limit_ff};

   assign integ_sat = pse_pkg::sat32(pse_pkg::SUM_W'(integ_ff) + prod_rnd);

   always_comb begin
      integ_in = integ_sat;
      if (!angle_mode_ff) begin
         if (integ_sat > limit_pos) begin
            integ_in = limit_pos;
         end else if (integ_sat < -limit_pos) begin
            integ_in = -limit_pos;
         end
      end
      // separation: large error clears the integral
      if (mag >= thresh) begin
         integ_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.ld_in) begin
         tgt_ff  <= req_target_value;
         meas_ff <= req_measured_value;
      end
      if (ctrl.ld_err) begin
         err_ff <= pse_pkg::sat32(pse_pkg::SUM_W'(diff));
      end else if (ctrl.ld_wrap) begin
         if (angle_mode_ff && (mag > (DW+1)'(pse_pkg::FX_PI))) begin
            err_ff <= err_ff[DW-1] ? err_ff + pse_pkg::FX_TWO_PI
                                   : err_ff - pse_pkg::FX_TWO_PI;
         end
      end
      if (ctrl.ld_acc) begin
         acc_ff <= prod_x;
      end else if (ctrl.add_acc) begin
         acc_ff <= acc_ff + prod_x;
      end
      if (ctrl.ld_filt) begin
         pd_ff <= prod_rnd;
      end else if (ctrl.add_dterm) begin
         pd_ff <= pd_ff + prod_rnd;
      end
      if (ctrl.ld_out) begin
         rsp_drive_ff <= pse_pkg::sat32(pd_ff + pse_pkg::SUM_W'(integ_ff));
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_err_ff <= '0;
         integ_ff    <= '0;
         filt_ff     <= '0;
      end else begin
         if (ctrl.ld_integ) begin
            integ_ff <= integ_in;
         end
         if (ctrl.ld_filt) begin
            filt_ff     <= pse_pkg::sat32(pse_pkg::SUM_W'(pse_pkg::round16(acc_ff)));
            prev_err_ff <= err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.ld_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = rsp_drive_ff;

   a_out_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.ld_out |-> !(rsp_valid_ff && rsp_stall))
      else $error("result loaded over a beat still waiting");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctrl.ld_out))
      else $error("result valid without a result step");

   a_clamp_linear: assert property (@(posedge clock) disable iff (reset)
      (ctrl.ld_integ && !angle_mode_ff) |=>
         (integ_ff <= limit_pos) && (integ_ff >= -limit_pos))
      else $error("integral outside the clamp in linear mode");

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the PID step with integral separation. Beats of
// target and measured value go in with random gaps. Drive values come back
// under random stalls. Each drive value is predicted in Q16.16 from a local
// copy of the gains, the error history, the integral and the filtered
// derivative, and checked in order.
// ----------------------------------------------------------------------------

localparam longint WORD_MAX     = 2147483647;
localparam longint WORD_MIN     = -WORD_MAX - 1;
localparam longint PI_Q16       = 205887;
localparam longint TWO_PI_Q16   = 411775;
localparam longint HALF_RAD_Q16 = 32768;
localparam longint THIRTY_Q16   = 1966080;
localparam longint FILTER_KEEP  = 45875;
localparam longint FILTER_TAKE  = 19661;

class drive_scoreboard;
   logic signed [pse_pkg::DATA_W-1:0] gain_p;
   logic signed [pse_pkg::DATA_W-1:0] gain_i;
   logic signed [pse_pkg::DATA_W-1:0] gain_d;
   logic [pse_pkg::DATA_W-2:0]        integral_limit;
   logic                              angle_mode;
   logic signed [pse_pkg::DATA_W-1:0] last_error;
   logic signed [pse_pkg::DATA_W-1:0] integral_acc;
   logic signed [pse_pkg::DATA_W-1:0] filt_deriv;
   logic signed [pse_pkg::DATA_W-1:0] drive_due[$];
   int                                mismatches;

   function new();
      gain_p         = '0;
      gain_i         = '0;
      gain_d         = '0;
      integral_limit = '0;
      angle_mode     = 1'b0;
      last_error     = '0;
      integral_acc   = '0;
      filt_deriv     = '0;
      mismatches     = 0;
   endfunction

   function void write_register(logic [pse_pkg::CSR_IDX_W-1:0] index,
                                logic [pse_pkg::DATA_W-1:0] data);
      case (index)
         pse_pkg::CSR_GAIN_P:         gain_p = data;
         pse_pkg::CSR_GAIN_I:         gain_i = data;
         pse_pkg::CSR_GAIN_D:         gain_d = data;
         pse_pkg::CSR_INTEGRAL_LIMIT: integral_limit = data[pse_pkg::DATA_W-2:0];
         pse_pkg::CSR_ANGLE_MODE:     angle_mode = data[0];
         default: ;
      endcase
   endfunction

   function longint clamp_word(longint v);
      if (v > WORD_MAX) return WORD_MAX;
      if (v < WORD_MIN) return WORD_MIN;
      return v;
   endfunction

   // half lsb up, then floor
   function longint round_q16(longint v);
      return (v + HALF_RAD_Q16) >>> 16;
   endfunction

   function void note_request(logic signed [pse_pkg::DATA_W-1:0] target,
                              logic signed [pse_pkg::DATA_W-1:0] measured);
      longint err;
      longint mag;
      longint band;
      longint acc;
      longint filt;
      longint total;
      err = clamp_word(longint'(target) - longint'(measured));
      if (angle_mode) begin
         mag = (err < 0) ? -err : err;
         if (mag > PI_Q16) begin
            err = (err > 0) ? err - TWO_PI_Q16 : err + TWO_PI_Q16;
         end
      end
      mag  = (err < 0) ? -err : err;
      band = angle_mode ? HALF_RAD_Q16 : THIRTY_Q16;
      if (mag < band) begin
         acc = clamp_word(longint'(integral_acc) + round_q16(err * longint'(gain_i)));
         if (!angle_mode) begin
            if (acc > longint'(integral_limit)) acc = longint'(integral_limit);
            if (acc < -longint'(integral_limit)) acc = -longint'(integral_limit);
         end
      end else begin
         acc = 0;
      end
      filt = clamp_word(round_q16(FILTER_KEEP * longint'(filt_deriv)
                                  + FILTER_TAKE * (err - longint'(last_error))));
      total = clamp_word(round_q16(err * longint'(gain_p))
                         + round_q16(filt * longint'(gain_d)) + acc);
      integral_acc = acc[pse_pkg::DATA_W-1:0];
      filt_deriv   = filt[pse_pkg::DATA_W-1:0];
      last_error   = err[pse_pkg::DATA_W-1:0];
      drive_due.push_back(total[pse_pkg::DATA_W-1:0]);
   endfunction

   function void check_drive(logic signed [pse_pkg::DATA_W-1:0] actual);
      logic signed [pse_pkg::DATA_W-1:0] want;
      if (drive_due.size() == 0) begin
         $display("%0t: drive_value, expected none, actual %0d", $time, actual);
         mismatches++;
      end else begin
         want = drive_due.pop_front();
         if (actual !== want) begin
            $display("%0t: drive_value, expected %0d, actual %0d", $time, want, actual);
            mismatches++;
         end
      end
   endfunction
endclass

module tb;

   localparam int CYCLE_LIMIT = 400000;
   localparam int IDLE_MAX    = 11;
   localparam int PHASE_COUNT = 8;
   localparam int PHASE_ITEMS = 166;
   localparam int GAIN_SPAN   = 262144;
   localparam int LIMIT_SPAN  = 4000000;
   localparam logic signed [pse_pkg::DATA_W-1:0] S_MAX = 32'sh7fffffff;
   localparam logic signed [pse_pkg::DATA_W-1:0] S_MIN = 32'sh80000000;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              csr_write_enable = 1'b0;
   logic [pse_pkg::CSR_IDX_W-1:0]     csr_index = '0;
   logic [pse_pkg::DATA_W-1:0]        csr_write_data = '0;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic signed [pse_pkg::DATA_W-1:0] req_target_value = '0;
   logic signed [pse_pkg::DATA_W-1:0] req_measured_value = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic signed [pse_pkg::DATA_W-1:0] rsp_drive_value;

   int gap_max     = IDLE_MAX;
   int stall_max   = IDLE_MAX;
   int stall_left  = 0;
   int cycle_count = 0;

   drive_scoreboard drive_check = new();

   pid_step_integral_separation_top dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // stall is raised ahead of the beat and held for the drawn count once it shows
   always @(posedge clock) begin : rsp_side
      int hold;
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (rsp_valid && !rsp_stall) begin
         drive_check.check_drive(rsp_drive_value);
         hold = $urandom_range(0, stall_max);
         stall_left <= hold;
         rsp_stall  <= (hold != 0);
      end else if (rsp_valid && stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall  <= (stall_left > 1);
      end
   end

   task automatic csr_write(input logic [pse_pkg::CSR_IDX_W-1:0] index,
                            input logic [pse_pkg::DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      drive_check.write_register(index, data);
   endtask

   task automatic configure(input logic [pse_pkg::DATA_W-1:0] kp,
                            input logic [pse_pkg::DATA_W-1:0] ki,
                            input logic [pse_pkg::DATA_W-1:0] kd,
                            input logic [pse_pkg::DATA_W-1:0] limit,
                            input logic [pse_pkg::DATA_W-1:0] mode);
      csr_write(pse_pkg::CSR_GAIN_P, kp);
      csr_write(pse_pkg::CSR_GAIN_I, ki);
      csr_write(pse_pkg::CSR_GAIN_D, kd);
      csr_write(pse_pkg::CSR_INTEGRAL_LIMIT, limit);
      csr_write(pse_pkg::CSR_ANGLE_MODE, mode);
   endtask

   task automatic send_sample(input logic signed [pse_pkg::DATA_W-1:0] target,
                              input logic signed [pse_pkg::DATA_W-1:0] measured);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_target_value   <= target;
      req_measured_value <= measured;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      drive_check.note_request(target, measured);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drive_check.drive_due.size() != 0) @(posedge clock);
   endtask

   function automatic logic [pse_pkg::DATA_W-1:0] pick_gain();
      case ($urandom_range(0, 9))
         0: return S_MAX;
         1: return S_MIN;
         2, 3: return $urandom();
         default: return $urandom_range(0, 2 * GAIN_SPAN) - GAIN_SPAN;
      endcase
   endfunction

   function automatic logic [pse_pkg::DATA_W-1:0] pick_limit();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return S_MAX;
         2: return $urandom();
         default: return $urandom_range(0, LIMIT_SPAN);
      endcase
   endfunction

   function automatic logic signed [pse_pkg::DATA_W-1:0] pick_extreme();
      case ($urandom_range(0, 4))
         0: return S_MAX;
         1: return S_MIN;
         2: return '0;
         3: return '1;
         default: return 32'sd1;
      endcase
   endfunction

   // mostly errors around the separation band, so the integral gets to work
   function automatic void pick_sample(input logic angle,
                                       output logic signed [pse_pkg::DATA_W-1:0] target,
                                       output logic signed [pse_pkg::DATA_W-1:0] measured);
      int     band;
      longint err;
      longint base;
      longint meas;
      band = angle ? int'(HALF_RAD_Q16) : int'(THIRTY_Q16);
      case ($urandom_range(0, 9))
         7: begin
            target   = $urandom();
            measured = $urandom();
         end
         8: begin
            target   = pick_extreme();
            measured = pick_extreme();
         end
         9: begin
            target   = $urandom();
            measured = target;
         end
         default: begin
            if ($urandom_range(0, 4) < 3) begin
               err = longint'($urandom_range(0, 2 * band - 2)) - (band - 1);
            end else begin
               err = longint'($urandom_range(0, 6 * band)) - 3 * band;
            end
            if (angle) begin
               case ($urandom_range(0, 5))
                  2: err = err + TWO_PI_Q16;
                  3: err = err - TWO_PI_Q16;
                  4: err = err + PI_Q16;
                  5: err = err - PI_Q16;
                  default: ;
               endcase
            end
            base     = longint'($signed($urandom())) >>> 1;
            meas     = base - err;
            target   = base[pse_pkg::DATA_W-1:0];
            measured = meas[pse_pkg::DATA_W-1:0];
         end
      endcase
   endfunction

   task automatic run_directed();
      int k;
      configure(32'sd98304, 32'sd16384, 32'sd32768, 32'd131072, '0);
      // writes past the last register must leave everything alone
      for (k = int'(pse_pkg::CSR_ANGLE_MODE) + 1; k < (1 << pse_pkg::CSR_IDX_W); k++) begin
         csr_write(k[pse_pkg::CSR_IDX_W-1:0], '1);
      end
      csr_write_enable <= 1'b0;
      send_sample('0, '0);
      send_sample(32'sd1966079, '0);
      send_sample(32'sd1966079, '0);
      send_sample('0, 32'sd1966079);
      send_sample(32'sd1966080, '0);
      send_sample('0, 32'sd1966080);
      send_sample(S_MAX, S_MIN);
      send_sample(S_MIN, S_MAX);
      send_sample(S_MAX, S_MAX);

      wait_drained();
      configure(S_MAX, S_MIN, S_MAX, S_MAX, '0);
      csr_write_enable <= 1'b0;
      send_sample(S_MAX, S_MIN);
      send_sample(S_MIN, S_MAX);
      send_sample(-32'sd1966079, '0);
      send_sample(-32'sd1966079, '0);
      send_sample(32'sd1966079, '0);
      send_sample(32'sd1, '0);

      // limit has only its top bit set, the mode word is all ones
      wait_drained();
      configure(S_MIN, S_MAX, S_MIN, 32'h80000000, '1);
      csr_write_enable <= 1'b0;
      send_sample(32'sd205887, '0);
      send_sample('0, -32'sd205888);
      send_sample(-32'sd205887, '0);
      send_sample('0, 32'sd205888);
      send_sample(32'sd32767, '0);
      send_sample(-32'sd32767, '0);
      send_sample(32'sd32768, '0);
      send_sample('0, 32'sd32768);
      send_sample(32'sd411875, '0);
      send_sample(S_MAX, S_MIN);
      send_sample(S_MIN, S_MAX);
   endtask

   task automatic run_random_phase(input int phase);
      logic                              angle;
      logic [pse_pkg::DATA_W-1:0]        mode_word;
      logic signed [pse_pkg::DATA_W-1:0] target;
      logic signed [pse_pkg::DATA_W-1:0] measured;
      angle = ((phase / 4) % 2) != 0;
      wait_drained();
      case (phase % 4)
         0: begin
            gap_max   = IDLE_MAX;
            stall_max = IDLE_MAX;
         end
         1: begin
            gap_max   = 0;
            stall_max = 0;
         end
         2: begin
            gap_max   = IDLE_MAX;
            stall_max = 0;
         end
         default: begin
            gap_max   = 0;
            stall_max = IDLE_MAX;
         end
      endcase
      mode_word    = $urandom();
      mode_word[0] = angle;
      configure(pick_gain(), pick_gain(), pick_gain(), pick_limit(), mode_word);
      csr_write_enable <= 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
         if ($urandom_range(0, 127) == 0) begin
            wait_drained();
         end
         pick_sample(angle, target, measured);
         send_sample(target, measured);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      run_directed();
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         run_random_phase(phase);
      end
      wait_drained();
      repeat (30) @(posedge clock);
      if (drive_check.mismatches == 0 && drive_check.drive_due.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/core/pse_pkg.sv
rtl/core/pse_mul.sv
rtl/core/pse_ctrl.sv
rtl/core/pid_step_integral_separation_top.sv
tb/sv/tb.sv
